// File: rtl/ps2kd_pkg.sv
// ----------------------------------------------------------------------------
// ps2kd_pkg
// Shared types, codes and the scan code set 2 ASCII table for the decoder.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

    localparam logic [1:0] MODE_SCAN  = 2'd0;
    localparam logic [1:0] MODE_TEST  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CODE_BREAK = 8'hF0;
    localparam logic [7:0] CODE_EXT   = 8'hE0;
    localparam logic [7:0] CODE_CAPS  = 8'h58;
    localparam logic [7:0] CODE_SCRL  = 8'h7E;
    localparam logic [7:0] CODE_NUM   = 8'h77;
    localparam logic [7:0] CODE_LSHF  = 8'h12;
    localparam logic [7:0] CODE_RSHF  = 8'h59;
    localparam logic [7:0] CMD_LEDS   = 8'hED;
    localparam logic [2:0] LED_CAPS   = 3'h4;
    localparam logic [2:0] LED_SCRL   = 3'h1;
    localparam logic [2:0] LED_NUM    = 3'h2;

    localparam int KEY_SLOTS = 256;
    localparam int SLOT_W    = 8;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_SEND = 2'd1,
        KIND_STAT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MAKE,
        OP_BREAK,
        OP_TEST,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_CHAR,
        RES_LED,
        RES_STAT
    } t_res;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] scan_byte;
        logic [7:0] key_index;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_out_item;

    // Decoded work handed from the front to the back.
    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        t_res              res;
        logic [7:0]        val;
    } t_cmd;

    function automatic logic [7:0] ascii_lookup(input logic shifted, input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'h0D: ch = shifted ? 8'h08 : 8'h09;
            7'h15: ch = shifted ? 8'h51 : 8'h71;
            7'h16: ch = shifted ? 8'h21 : 8'h31;
            7'h1A: ch = shifted ? 8'h5A : 8'h7A;
            7'h1B: ch = shifted ? 8'h53 : 8'h73;
            7'h1C: ch = shifted ? 8'h41 : 8'h61;
            7'h1D: ch = shifted ? 8'h57 : 8'h77;
            7'h1E: ch = shifted ? 8'h22 : 8'h32;
            7'h21: ch = shifted ? 8'h43 : 8'h63;
            7'h22: ch = shifted ? 8'h58 : 8'h78;
            7'h23: ch = shifted ? 8'h44 : 8'h64;
            7'h24: ch = shifted ? 8'h45 : 8'h65;
            7'h25: ch = shifted ? 8'h24 : 8'h34;
            7'h26: ch = shifted ? 8'hA3 : 8'h33;
            7'h29: ch = 8'h20;
            7'h2A: ch = shifted ? 8'h56 : 8'h76;
            7'h2B: ch = shifted ? 8'h46 : 8'h66;
            7'h2C: ch = shifted ? 8'h54 : 8'h74;
            7'h2D: ch = shifted ? 8'h52 : 8'h72;
            7'h2E: ch = shifted ? 8'h25 : 8'h35;
            7'h31: ch = shifted ? 8'h4E : 8'h6E;
            7'h32: ch = shifted ? 8'h42 : 8'h62;
            7'h33: ch = shifted ? 8'h48 : 8'h68;
            7'h34: ch = shifted ? 8'h47 : 8'h67;
            7'h35: ch = shifted ? 8'h59 : 8'h79;
            7'h36: ch = shifted ? 8'h5E : 8'h36;
            7'h3A: ch = shifted ? 8'h4D : 8'h6D;
            7'h3B: ch = shifted ? 8'h4A : 8'h6A;
            7'h3C: ch = shifted ? 8'h55 : 8'h75;
            7'h3D: ch = shifted ? 8'h26 : 8'h37;
            7'h3E: ch = shifted ? 8'h2A : 8'h38;
            7'h41: ch = shifted ? 8'h3C : 8'h2C;
            7'h42: ch = shifted ? 8'h4B : 8'h6B;
            7'h43: ch = shifted ? 8'h49 : 8'h69;
            7'h44: ch = shifted ? 8'h4F : 8'h6F;
            7'h45: ch = shifted ? 8'h29 : 8'h30;
            7'h46: ch = shifted ? 8'h28 : 8'h39;
            7'h49: ch = shifted ? 8'h3E : 8'h2E;
            7'h4A: ch = shifted ? 8'h3F : 8'h2F;
            7'h4B: ch = shifted ? 8'h4C : 8'h6C;
            7'h4C: ch = shifted ? 8'h3A : 8'h3B;
            7'h4D: ch = shifted ? 8'h50 : 8'h70;
            7'h4E: ch = shifted ? 8'h5F : 8'h2D;
            7'h52: ch = shifted ? 8'h3F : 8'h27;
            7'h54: ch = shifted ? 8'h7B : 8'h5B;
            7'h55: ch = shifted ? 8'h2B : 8'h3D;
            7'h5A: ch = 8'h0A;
            7'h5B: ch = shifted ? 8'h7D : 8'h5D;
            7'h5D: ch = shifted ? 8'h7E : 8'h23;
            7'h66: ch = shifted ? 8'h09 : 8'h08;
            // keypad: same in both planes
            7'h69: ch = 8'h31;
            7'h6B: ch = 8'h34;
            7'h6C: ch = 8'h37;
            7'h70: ch = 8'h30;
            7'h71: ch = 8'h2E;
            7'h72: ch = 8'h32;
            7'h73: ch = 8'h35;
            7'h74: ch = 8'h36;
            7'h75: ch = 8'h38;
            7'h76: ch = 8'h1B;
            7'h79: ch = 8'h2B;
            7'h7A: ch = 8'h33;
            7'h7C: ch = 8'h2A;
            7'h7D: ch = 8'h39;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/ps2_keyboard_decoder_top.sv
// ----------------------------------------------------------------------------
// ps2_keyboard_decoder_top
// PS/2 scan code set 2 decoder with key status table and lock LED control.
// ----------------------------------------------------------------------------
// Flow: an accepted item is written into the queue and popped from it into the
// result register once that register is free; the result is shown from there.
// Throughput: one item per cycle while o_stall is low; a lock key item holds the
// result register for both bytes it sends, the LED command and then the LED byte.
// Reset: synchronous, active low; clears prefix, shift and LED state, the queue
// and the per-slot valid bits, so the key table reads as all zero at once.
// ----------------------------------------------------------------------------
module ps2_keyboard_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ps2kd_pkg::t_in_item  i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output ps2kd_pkg::t_out_item o_data,
    input  logic                 i_stall
);

    logic            q_push, q_pop, q_valid, q_full;
    ps2kd_pkg::t_cmd f_cmd, q_cmd;

    // stall the input only when the queue has no room
    assign o_stall = q_full;

    // front: decode each item and update prefix, shift and LED state in order
    ps2kd_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (f_cmd)
    );

    // hold decoded commands so each side can stall on its own
    ps2kd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (f_cmd),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_cmd  (q_cmd)
    );

    // back: update the key table and deliver result items
    ps2kd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule

// File: rtl/ps2kd_ram.sv
// ----------------------------------------------------------------------------
// ps2kd_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module ps2kd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ps2kd_front.sv
// ----------------------------------------------------------------------------
// ps2kd_front
// Accept items, track prefix, shift and LED state, and issue table commands.
// ----------------------------------------------------------------------------
module ps2kd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ps2kd_pkg::t_in_item i_data,
    input  logic                i_full,
    output logic                o_push,
    output ps2kd_pkg::t_cmd     o_cmd
);

    logic       r_brk, r_ext, r_shift;
    logic [2:0] r_leds;
    logic       n_brk, n_ext, n_shift;
    logic [2:0] n_leds;
    logic       acc;
    logic [7:0] code;
    logic [7:0] ch;
    logic [2:0] toggle;
    ps2kd_pkg::t_cmd cmd;

    assign acc  = i_valid && !i_full;
    assign code = i_data.scan_byte;
    assign ch   = ps2kd_pkg::ascii_lookup(r_shift || r_leds[2], code[6:0]);

    always_comb begin
        n_brk   = r_brk;
        n_ext   = r_ext;
        n_shift = r_shift;
        n_leds  = r_leds;
        toggle  = 3'd0;
        cmd.op   = ps2kd_pkg::OP_NONE;
        cmd.slot = i_data.key_index;
        cmd.res  = ps2kd_pkg::RES_NONE;
        cmd.val  = 8'd0;
        case (i_data.mode)
            ps2kd_pkg::MODE_SCAN: begin
                if (code == ps2kd_pkg::CODE_BREAK) begin
                    n_brk = 1'b1;
                end else if (code == ps2kd_pkg::CODE_EXT) begin
                    n_ext = 1'b1;
                end else begin
                    n_brk    = 1'b0;
                    n_ext    = 1'b0;
                    cmd.slot = r_ext ? (code + 8'd128) : code;
                    if (r_brk) begin
                        cmd.op = ps2kd_pkg::OP_BREAK;
                        if (code == ps2kd_pkg::CODE_LSHF || code == ps2kd_pkg::CODE_RSHF) begin
                            n_shift = 1'b0;
                        end
                    end else begin
                        cmd.op = ps2kd_pkg::OP_MAKE;
                        if (!r_ext && !code[7] && ch != 8'd0) begin
                            cmd.res = ps2kd_pkg::RES_CHAR;
                            cmd.val = ch;
                        end else begin
                            case (code)
                                ps2kd_pkg::CODE_CAPS: toggle  = ps2kd_pkg::LED_CAPS;
                                ps2kd_pkg::CODE_SCRL: toggle  = ps2kd_pkg::LED_SCRL;
                                ps2kd_pkg::CODE_NUM:  toggle  = ps2kd_pkg::LED_NUM;
                                ps2kd_pkg::CODE_LSHF: n_shift = 1'b1;
                                ps2kd_pkg::CODE_RSHF: n_shift = 1'b1;
                                default: toggle = 3'd0;
                            endcase
                            if (toggle != 3'd0) begin
                                n_leds  = r_leds ^ toggle;
                                cmd.res = ps2kd_pkg::RES_LED;
                                cmd.val = {5'd0, n_leds};
                            end
                        end
                    end
                end
            end
            ps2kd_pkg::MODE_TEST: begin
                cmd.op  = ps2kd_pkg::OP_TEST;
                cmd.res = ps2kd_pkg::RES_STAT;
            end
            ps2kd_pkg::MODE_CLEAR: begin
                cmd.op = ps2kd_pkg::OP_CLEAR;
            end
            default: cmd.op = ps2kd_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk   <= 1'b0;
            r_ext   <= 1'b0;
            r_shift <= 1'b0;
            r_leds  <= 3'd0;
        end else if (acc) begin
            r_brk   <= n_brk;
            r_ext   <= n_ext;
            r_shift <= n_shift;
            r_leds  <= n_leds;
        end
    end

    assign o_push = acc && (cmd.op != ps2kd_pkg::OP_NONE);
    assign o_cmd  = cmd;

endmodule

// File: rtl/ps2kd_queue.sv
// ----------------------------------------------------------------------------
// ps2kd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ps2kd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ps2kd_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output ps2kd_pkg::t_cmd o_cmd
);

    ps2kd_pkg::t_cmd r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_mem[r_rp];

endmodule

// File: rtl/ps2kd_back.sv
// ----------------------------------------------------------------------------
// ps2kd_back
// Carry out key table commands and drive the result register.
// ----------------------------------------------------------------------------
module ps2kd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  ps2kd_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    output ps2kd_pkg::t_out_item o_data,
    input  logic                 i_stall
);

    // held and sticky bits live in separate stores so every write is blind;
    // one valid bit per slot marks slots written since the last clear, and the
    // first write to a slot fills both stores so the bit covers the pair
    logic [ps2kd_pkg::KEY_SLOTS-1:0] r_vld;
    logic            r_vq;
    logic            held_rd, stky_rd;
    logic            held_we, stky_we, wd_set, is_test, is_make, is_break, vld_now;
    logic            r_y_valid, r_y_phase;
    ps2kd_pkg::t_res r_y_res;
    logic [7:0]      r_y_val;
    logic            out_acc, out_last, y_free;

    assign is_test  = (i_cmd.op == ps2kd_pkg::OP_TEST);
    assign is_make  = (i_cmd.op == ps2kd_pkg::OP_MAKE);
    assign is_break = (i_cmd.op == ps2kd_pkg::OP_BREAK);
    assign vld_now  = r_vld[i_cmd.slot];
    assign wd_set   = is_make;
    assign held_we  = o_pop && (is_make || is_break || (is_test && !vld_now));
    assign stky_we  = o_pop && (is_make || is_test || (is_break && !vld_now));

    ps2kd_ram #(.WIDTH(1), .DEPTH(ps2kd_pkg::KEY_SLOTS)) u_held (
        .i_clk  (i_clk),
        .i_we   (held_we),
        .i_waddr(i_cmd.slot),
        .i_wdata(wd_set),
        .i_re   (o_pop && is_test),
        .i_raddr(i_cmd.slot),
        .o_rdata(held_rd)
    );

    ps2kd_ram #(.WIDTH(1), .DEPTH(ps2kd_pkg::KEY_SLOTS)) u_stky (
        .i_clk  (i_clk),
        .i_we   (stky_we),
        .i_waddr(i_cmd.slot),
        .i_wdata(wd_set),
        .i_re   (o_pop && is_test),
        .i_raddr(i_cmd.slot),
        .o_rdata(stky_rd)
    );

    assign out_last = (r_y_res == ps2kd_pkg::RES_LED) ? r_y_phase : 1'b1;
    assign out_acc  = r_y_valid && !i_stall;
    assign y_free   = !r_y_valid || (out_acc && out_last);
    assign o_pop    = i_cmd_valid && y_free;

    always_ff @(posedge i_clk) begin
        if (o_pop && is_test) begin
            r_vq <= vld_now;
        end
        if (o_pop) begin
            r_y_res <= i_cmd.res;
            r_y_val <= i_cmd.val;
        end
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_y_valid <= 1'b0;
            r_y_phase <= 1'b0;
        end else begin
            if (o_pop && i_cmd.op == ps2kd_pkg::OP_CLEAR) begin
                r_vld <= '0;
            end else if (o_pop && (is_make || is_break || is_test)) begin
                r_vld[i_cmd.slot] <= 1'b1;
            end
            if (o_pop) begin
                r_y_valid <= (i_cmd.res != ps2kd_pkg::RES_NONE);
                r_y_phase <= 1'b0;
            end else if (out_acc && out_last) begin
                r_y_valid <= 1'b0;
            end else if (out_acc) begin
                r_y_phase <= 1'b1;
            end
        end
    end

    always_comb begin
        o_data.last = out_last;
        case (r_y_res)
            ps2kd_pkg::RES_LED: begin
                o_data.kind  = ps2kd_pkg::KIND_SEND;
                o_data.value = r_y_phase ? r_y_val : ps2kd_pkg::CMD_LEDS;
            end
            ps2kd_pkg::RES_STAT: begin
                o_data.kind  = ps2kd_pkg::KIND_STAT;
                o_data.value = {6'd0, stky_rd && r_vq, held_rd && r_vq};
            end
            default: begin
                o_data.kind  = ps2kd_pkg::KIND_CHAR;
                o_data.value = r_y_val;
            end
        endcase
    end

    assign o_valid = r_y_valid;

endmodule

// File: rtl/ps2kd_checker.sv
// ----------------------------------------------------------------------------
// ps2kd_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2kd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input ps2kd_pkg::t_out_item o_data,
    input logic                 i_stall
);

    // a status result is always final and only two bits wide
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == ps2kd_pkg::KIND_STAT) |-> (o_data.last && o_data.value[7:2] == 6'd0))
        else $error("bad status result");

    // the first byte of an LED pair is the LED command
    a_ledcmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == ps2kd_pkg::KIND_SEND && !o_data.last)
            |-> (o_data.value == ps2kd_pkg::CMD_LEDS))
        else $error("LED command byte wrong");

    // after the LED command is taken, the LED byte follows
    a_ledbyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_data.kind == ps2kd_pkg::KIND_SEND && !o_data.last)
            |=> (o_valid && o_data.kind == ps2kd_pkg::KIND_SEND && o_data.last
                 && o_data.value[7:3] == 5'd0))
        else $error("LED byte missing");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind ps2_keyboard_decoder_top ps2kd_checker u_ps2kd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .o_data (o_data),
    .i_stall(i_stall)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the PS/2 scan code decoder with directed and random items and checks
// every result against a scoreboard predictor of key table, prefix and LEDs.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    ps2kd_pkg::t_in_item  i_data;
    logic                 o_stall;
    logic                 o_valid;
    ps2kd_pkg::t_out_item o_data;
    logic                 i_stall;

    ps2_keyboard_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // Predictor state: a private copy of the decoder's state.
    logic [1:0] key_tbl [ps2kd_pkg::KEY_SLOTS];
    logic       brk_seen;
    logic       ext_seen;
    logic       shift_on;
    logic [2:0] leds;

    ps2kd_pkg::t_in_item  pending_items [$];
    ps2kd_pkg::t_out_item expected_results [$];
    int        errors;
    int        items_sent;
    int        results_seen;
    bit        quiet_tail;      // no idling in the last stretch
    bit        hold_sender;     // pause sender until results drain

    // Expected ASCII for a plain make code, built from the scan code set 2 layout.
    function automatic logic [7:0] char_for(input logic sh, input logic [6:0] c);
        case (c)
            7'h0D: return sh ? 8'h08 : 8'h09;
            7'h15: return sh ? "Q" : "q";
            7'h16: return sh ? "!" : "1";
            7'h1A: return sh ? "Z" : "z";
            7'h1B: return sh ? "S" : "s";
            7'h1C: return sh ? "A" : "a";
            7'h1D: return sh ? "W" : "w";
            7'h1E: return sh ? 8'h22 : "2";
            7'h21: return sh ? "C" : "c";
            7'h22: return sh ? "X" : "x";
            7'h23: return sh ? "D" : "d";
            7'h24: return sh ? "E" : "e";
            7'h25: return sh ? "$" : "4";
            7'h26: return sh ? 8'hA3 : "3";
            7'h29: return " ";
            7'h2A: return sh ? "V" : "v";
            7'h2B: return sh ? "F" : "f";
            7'h2C: return sh ? "T" : "t";
            7'h2D: return sh ? "R" : "r";
            7'h2E: return sh ? "%" : "5";
            7'h31: return sh ? "N" : "n";
            7'h32: return sh ? "B" : "b";
            7'h33: return sh ? "H" : "h";
            7'h34: return sh ? "G" : "g";
            7'h35: return sh ? "Y" : "y";
            7'h36: return sh ? "^" : "6";
            7'h3A: return sh ? "M" : "m";
            7'h3B: return sh ? "J" : "j";
            7'h3C: return sh ? "U" : "u";
            7'h3D: return sh ? "&" : "7";
            7'h3E: return sh ? "*" : "8";
            7'h41: return sh ? "<" : ",";
            7'h42: return sh ? "K" : "k";
            7'h43: return sh ? "I" : "i";
            7'h44: return sh ? "O" : "o";
            7'h45: return sh ? ")" : "0";
            7'h46: return sh ? "(" : "9";
            7'h49: return sh ? ">" : ".";
            7'h4A: return sh ? "?" : "/";
            7'h4B: return sh ? "L" : "l";
            7'h4C: return sh ? ":" : ";";
            7'h4D: return sh ? "P" : "p";
            7'h4E: return sh ? "_" : "-";
            7'h52: return sh ? "?" : 8'h27;
            7'h54: return sh ? "{" : "[";
            7'h55: return sh ? "+" : "=";
            7'h5A: return 8'h0A;
            7'h5B: return sh ? "}" : "]";
            7'h5D: return sh ? "~" : "#";
            7'h66: return sh ? 8'h09 : 8'h08;
            7'h69: return "1";
            7'h6B: return "4";
            7'h6C: return "7";
            7'h70: return "0";
            7'h71: return ".";
            7'h72: return "2";
            7'h73: return "5";
            7'h74: return "6";
            7'h75: return "8";
            7'h76: return 8'h1B;
            7'h79: return "+";
            7'h7A: return "3";
            7'h7C: return "*";
            7'h7D: return "9";
            default: return 8'h00;
        endcase
    endfunction

    function automatic ps2kd_pkg::t_out_item make_result(input ps2kd_pkg::t_kind k,
                                                         input logic [7:0] v,
                                                         input logic l);
        ps2kd_pkg::t_out_item r;
        r.kind  = k;
        r.value = v;
        r.last  = l;
        return r;
    endfunction

    // Advance the predictor by one accepted item and queue its results.
    task automatic decode_item(input ps2kd_pkg::t_in_item it);
        logic [7:0] slot;
        logic [7:0] ch;
        logic [2:0] flip;
        logic       brk;
        logic       ext;
        logic [1:0] st;
        brk  = brk_seen;
        ext  = ext_seen;
        flip = 3'b000;
        case (it.mode)
            ps2kd_pkg::MODE_SCAN: begin
                if (it.scan_byte == ps2kd_pkg::CODE_BREAK) begin
                    brk_seen = 1'b1;
                end else if (it.scan_byte == ps2kd_pkg::CODE_EXT) begin
                    ext_seen = 1'b1;
                end else begin
                    brk_seen = 1'b0;
                    ext_seen = 1'b0;
                    slot = ext ? (8'd128 + it.scan_byte) : it.scan_byte;
                    if (brk) begin
                        key_tbl[slot] = key_tbl[slot] & 2'b10;
                        if (it.scan_byte == ps2kd_pkg::CODE_LSHF ||
                            it.scan_byte == ps2kd_pkg::CODE_RSHF)
                            shift_on = 1'b0;
                    end else begin
                        key_tbl[slot] = 2'b11;
                        ch = 8'h00;
                        if (!ext && !it.scan_byte[7])
                            ch = char_for(shift_on | leds[2], it.scan_byte[6:0]);
                        if (ch != 8'h00) begin
                            expected_results.push_back(
                                make_result(ps2kd_pkg::KIND_CHAR, ch, 1'b1));
                        end else begin
                            case (it.scan_byte)
                                ps2kd_pkg::CODE_CAPS: flip = ps2kd_pkg::LED_CAPS;
                                ps2kd_pkg::CODE_SCRL: flip = ps2kd_pkg::LED_SCRL;
                                ps2kd_pkg::CODE_NUM:  flip = ps2kd_pkg::LED_NUM;
                                ps2kd_pkg::CODE_LSHF, ps2kd_pkg::CODE_RSHF: shift_on = 1'b1;
                                default: ;
                            endcase
                            if (flip != 3'b000) begin
                                leds = leds ^ flip;
                                expected_results.push_back(make_result(
                                    ps2kd_pkg::KIND_SEND, ps2kd_pkg::CMD_LEDS, 1'b0));
                                expected_results.push_back(make_result(
                                    ps2kd_pkg::KIND_SEND, {5'b0, leds}, 1'b1));
                            end
                        end
                    end
                end
            end
            ps2kd_pkg::MODE_TEST: begin
                st = key_tbl[it.key_index];
                key_tbl[it.key_index] = st & 2'b01;
                expected_results.push_back(
                    make_result(ps2kd_pkg::KIND_STAT, {6'b0, st}, 1'b1));
            end
            ps2kd_pkg::MODE_CLEAR: begin
                foreach (key_tbl[k]) key_tbl[k] = 2'b00;
            end
            default: ;
        endcase
    endtask

    function automatic ps2kd_pkg::t_in_item mk(input logic [1:0] m, input logic [7:0] b,
                                               input logic [7:0] k);
        ps2kd_pkg::t_in_item it;
        it.mode      = m;
        it.scan_byte = b;
        it.key_index = k;
        return it;
    endfunction

    // Queue a scan byte with random junk in the unused field.
    task automatic push_scan(input logic [7:0] b);
        pending_items.push_back(mk(ps2kd_pkg::MODE_SCAN, b, 8'($urandom)));
    endtask

    // Well-formed key event: optional extended prefix, make or break.
    task automatic push_key(input logic [7:0] c, input bit ext, input bit brk);
        if (ext) push_scan(ps2kd_pkg::CODE_EXT);
        if (brk) push_scan(ps2kd_pkg::CODE_BREAK);
        push_scan(c);
    endtask

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return ps2kd_pkg::CODE_LSHF;
            1: return ps2kd_pkg::CODE_RSHF;
            2: return ps2kd_pkg::CODE_CAPS;
            3: return ps2kd_pkg::CODE_SCRL;
            4: return ps2kd_pkg::CODE_NUM;
            5: return 8'($urandom);
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Sender: present the next pending item, hold it while stalled, idle in bursts.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_item(i_data);
                items_sent = items_sent + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (hold_sender || pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= $urandom_range(0, 14);
                end else begin
                    i_valid <= 1'b1;
                    i_data  <= pending_items.pop_front();
                end
            end
        end
    end

    // Receiver: check each accepted result, stall in random bursts.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen = results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d value=%h last=%b", $time,
                             o_data.kind, o_data.value, o_data.last);
                    errors = errors + 1;
                end else begin
                    ps2kd_pkg::t_out_item want;
                    want = expected_results.pop_front();
                    if (want.kind !== o_data.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time,
                                 want.kind, o_data.kind);
                        errors = errors + 1;
                    end
                    if (want.value !== o_data.value) begin
                        $display("%0t: value expected %h actual %h", $time,
                                 want.value, o_data.value);
                        errors = errors + 1;
                    end
                    if (want.last !== o_data.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, o_data.last);
                        errors = errors + 1;
                    end
                end
            end
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!quiet_tail && $urandom_range(0, 24) == 0) begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(0, 14);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;
        int prev_cnt;
        int r;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        quiet_tail   = 1'b0;
        hold_sender  = 1'b0;
        brk_seen = 1'b0;
        ext_seen = 1'b0;
        shift_on = 1'b0;
        leds     = 3'b000;
        foreach (key_tbl[k]) key_tbl[k] = 2'b00;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: characters, shift, caps, lock keys, extended wrap, test, clear.
        push_key(8'h1C, 0, 0);                          // plain 'a'
        push_key(ps2kd_pkg::CODE_LSHF, 0, 0);           // shift held
        push_key(8'h26, 0, 0);                          // pound sign
        push_key(ps2kd_pkg::CODE_LSHF, 0, 1);           // shift released
        push_key(ps2kd_pkg::CODE_CAPS, 0, 0);           // caps on, two sends
        push_key(8'h15, 0, 0);                          // caps acts as shift
        push_key(ps2kd_pkg::CODE_SCRL, 1, 0);           // lock key via extended prefix
        push_key(ps2kd_pkg::CODE_NUM, 0, 0);
        push_key(8'hFF, 0, 0);                          // plain code >= 128
        push_key(8'h90, 1, 0);                          // extended wrap to slot 0x10
        pending_items.push_back(mk(ps2kd_pkg::MODE_TEST, 8'hFF, 8'h10));
        pending_items.push_back(mk(ps2kd_pkg::MODE_TEST, 8'h00, 8'h1C));
        push_key(8'h1C, 0, 1);
        pending_items.push_back(mk(ps2kd_pkg::MODE_TEST, 8'h00, 8'h1C));
        pending_items.push_back(mk(ps2kd_pkg::MODE_TEST, 8'h00, 8'hFF));
        pending_items.push_back(mk(ps2kd_pkg::MODE_CLEAR, 8'hAA, 8'h55));
        pending_items.push_back(mk(ps2kd_pkg::MODE_TEST, 8'h00, 8'h26));
        pending_items.push_back(mk(2'd3, 8'h1C, 8'h1C));  // unused mode
        push_key(ps2kd_pkg::CODE_CAPS, 0, 0);           // caps off again

        // Pressure: hold the sender until the directed results drain.
        wait (pending_items.size() == 0 && !i_valid);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        @(posedge i_clk);
        hold_sender = 1'b0;

        n = 0;
        while (n < 1950) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                prev_cnt = pending_items.size();
                push_key(pick_code(), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
                n = n + pending_items.size() - prev_cnt;
            end else if (r < 85) begin
                pending_items.push_back(mk(ps2kd_pkg::MODE_TEST, 8'($urandom),
                                           8'($urandom)));
                n = n + 1;
            end else if (r < 88) begin
                pending_items.push_back(mk(ps2kd_pkg::MODE_CLEAR, 8'($urandom),
                                           8'($urandom)));
                n = n + 1;
            end else if (r < 90) begin
                pending_items.push_back(mk(2'd3, 8'($urandom), 8'($urandom)));
            end else begin
                push_scan(8'($urandom));                // noise and stray prefixes
                n = n + 1;
            end
            if (n > 1700) quiet_tail = 1'b1;
            if (pending_items.size() > 64)
                wait (pending_items.size() < 16);
        end

        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d items and %0d results: chars, shift/caps, lock LEDs,",
                 items_sent, results_seen);
        $display("extended slots, status tests, table clears and random noise.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
